@@ hdl/ssed_pkg.sv @@
// package for the scale-space extremum detector; no dependencies
// holds register indexes, widths and resets, min frame side, queue sizes
`timescale 1ns / 1ps
`default_nettype none

package ssed_pkg;

   // configuration register map
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH        = 2'd0,
      CSR_FRAME_HEIGHT       = 2'd1,
      CSR_RESPONSE_THRESHOLD = 2'd2
   } csr_index_type;

   localparam int CFG_SIZE_BITS      = 12;
   localparam int CFG_THRESHOLD_BITS = 15;
   localparam int CSR_DATA_BITS      = CFG_THRESHOLD_BITS;

   localparam int FRAME_WIDTH_RESET        = 640;
   localparam int FRAME_HEIGHT_RESET       = 480;
   localparam int RESPONSE_THRESHOLD_RESET = 128;

   // smallest frame side that still has an interior pixel
   localparam int MIN_SIZE = 3;

   // result queue between the compare stage and the rsp channel
   localparam int RESULT_DEPTH      = 4;
   localparam int RESULT_PTR_BITS   = 2;
   localparam int RESULT_COUNT_BITS = 3;

endpackage : ssed_pkg

`default_nettype wire

@@ hdl/ssed_ram.sv @@
// generic single-clock ram, one write port and one registered read port
// read returns the old contents when the same entry is written in that cycle; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ssed_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule : ssed_ram

`default_nettype wire

@@ hdl/scale_space_extremum_detector.sv @@
// top level of the 3x3x3 difference-of-gaussian extremum detector
// depends on ssed_pkg and ssed_ram (two line stores)
`timescale 1ns / 1ps
`default_nettype none

// Takes one pixel position per clock while req_tready is high, in raster order, carrying
// the below, middle and above layer samples; a result for the centre one row up and one
// column left of that position is queued by the compare stage and offered on rsp once older
// results leave. Throughput, with req_tready high, is one item per cycle,
// set by the two line stores: each is read at the item's column in the accept cycle and
// written back at the same column in the next cycle, with the written row forwarded when
// the following item reads that same column. A four-entry result queue decouples rsp, so
// req_tready falls only when the queue plus the item in the compare stage could overflow
// it. The line stores are not cleared after reset; entries not yet written this frame are
// only ever read for border positions, which never give a result.
module scale_space_extremum_detector
   import ssed_pkg::*;
#(
   parameter int MAX_WIDTH   = 2048,
   parameter int MAX_HEIGHT  = 2048,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,

   // bits from 0: sample_below, sample_middle, sample_above, zero fill
   input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // bit 0: frame_start
   input  wire logic                                req_tuser,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,

   // bits from 0: center_col, center_row, response, zero fill
   output logic [(($clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   // bit 0: is_maximum
   output logic                                     rsp_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,

   input  wire logic                                csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0]           csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]            csr_wdata
);

   localparam int CW         = $clog2(MAX_WIDTH);
   localparam int RB         = $clog2(MAX_HEIGHT);
   localparam int CWP        = CW + 1;
   localparam int RBP        = RB + 1;
   localparam int TRIO_BITS  = 3 * SAMPLE_BITS;
   localparam int RSP_BITS   = ((CW + RB + SAMPLE_BITS + 7) / 8) * 8;
   localparam int ENTRY_BITS = CW + RB + SAMPLE_BITS + 1;
   localparam int WIDE_W     = (CWP > CFG_SIZE_BITS) ? CWP : CFG_SIZE_BITS;
   localparam int WIDE_H     = (RBP > CFG_SIZE_BITS) ? RBP : CFG_SIZE_BITS;
   localparam int MAG_BITS   = (SAMPLE_BITS > CFG_THRESHOLD_BITS) ? SAMPLE_BITS
                                                                   : CFG_THRESHOLD_BITS;

   function automatic logic [CWP-1:0] clamp_width(input logic [CFG_SIZE_BITS-1:0] v);
      logic [WIDE_W-1:0] x;
      x = WIDE_W'(v);
      if (x < WIDE_W'(MIN_SIZE)) begin
         x = WIDE_W'(MIN_SIZE);
      end else if (x > WIDE_W'(MAX_WIDTH)) begin
         x = WIDE_W'(MAX_WIDTH);
      end
      return CWP'(x);
   endfunction

   function automatic logic [RBP-1:0] clamp_height(input logic [CFG_SIZE_BITS-1:0] v);
      logic [WIDE_H-1:0] x;
      x = WIDE_H'(v);
      if (x < WIDE_H'(MIN_SIZE)) begin
         x = WIDE_H'(MIN_SIZE);
      end else if (x > WIDE_H'(MAX_HEIGHT)) begin
         x = WIDE_H'(MAX_HEIGHT);
      end
      return RBP'(x);
   endfunction

   // configuration; frame sizes kept already clamped
   logic [CWP-1:0]                width_ff;
   logic [RBP-1:0]                height_ff;
   logic [CFG_THRESHOLD_BITS-1:0] threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= clamp_width(CFG_SIZE_BITS'(FRAME_WIDTH_RESET));
         height_ff    <= clamp_height(CFG_SIZE_BITS'(FRAME_HEIGHT_RESET));
         threshold_ff <= CFG_THRESHOLD_BITS'(RESPONSE_THRESHOLD_RESET);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH: begin
               width_ff <= clamp_width(csr_wdata[CFG_SIZE_BITS-1:0]);
            end
            CSR_FRAME_HEIGHT: begin
               height_ff <= clamp_height(csr_wdata[CFG_SIZE_BITS-1:0]);
            end
            CSR_RESPONSE_THRESHOLD: begin
               threshold_ff <= csr_wdata[CFG_THRESHOLD_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- accept stage
   logic           req_accept;
   logic [CW-1:0]  col_ff, col_in;
   logic [RB-1:0]  row_ff, row_in;
   logic [CWP-1:0] pos_col_w, next_col_w;
   logic [RBP-1:0] pos_row_w, next_row_w;
   logic [CW-1:0]  pos_col;
   logic [RB-1:0]  pos_row;
   logic           pos_interior;

   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      pos_col_w = req_tuser ? '0 : CWP'(col_ff);
      pos_row_w = req_tuser ? '0 : RBP'(row_ff);
      // position beyond a shrunk size wraps as at a row end
      if (pos_col_w >= width_ff) begin
         pos_col_w = '0;
         pos_row_w = pos_row_w + RBP'(1);
      end
      if (pos_row_w >= height_ff) begin
         pos_row_w = '0;
      end
      pos_col = pos_col_w[CW-1:0];
      pos_row = pos_row_w[RB-1:0];
      pos_interior = (pos_col_w >= CWP'(2)) && (pos_row_w >= RBP'(2));

      next_col_w = pos_col_w + CWP'(1);
      next_row_w = pos_row_w;
      if (next_col_w >= width_ff) begin
         next_col_w = '0;
         next_row_w = pos_row_w + RBP'(1);
         if (next_row_w >= height_ff) begin
            next_row_w = '0;
         end
      end
      col_in = next_col_w[CW-1:0];
      row_in = next_row_w[RB-1:0];
   end

   // ---------------------------------------------------------------- compare stage
   logic                 s1_valid_ff;
   logic [CW-1:0]        s1_col_ff;
   logic [RB-1:0]        s1_row_ff;
   logic                 s1_interior_ff;
   logic [TRIO_BITS-1:0] s1_sample_ff;
   logic                 fwd_valid_ff, fwd_valid_in;
   logic [TRIO_BITS-1:0] fwd_older_ff, fwd_newer_ff;
   logic [TRIO_BITS-1:0] older_rd, newer_rd;
   logic [TRIO_BITS-1:0] older_eff, newer_eff;
   logic [TRIO_BITS-1:0] window_ff [3][2];

   // the item in the compare stage writes the column that the next item may read
   assign fwd_valid_in = req_accept && s1_valid_ff && (pos_col == s1_col_ff);

   ssed_ram #(
      .WIDTH (TRIO_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_older (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (newer_eff),
      .rd_en   (req_accept),
      .rd_addr (pos_col),
      .rd_data (older_rd)
   );

   ssed_ram #(
      .WIDTH (TRIO_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_newer (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_sample_ff),
      .rd_en   (req_accept),
      .rd_addr (pos_col),
      .rd_data (newer_rd)
   );

   assign older_eff = fwd_valid_ff ? fwd_older_ff : older_rd;
   assign newer_eff = fwd_valid_ff ? fwd_newer_ff : newer_rd;

   logic [TRIO_BITS-1:0]          cube [3][3];
   logic signed [SAMPLE_BITS-1:0] center;
   logic [SAMPLE_BITS-1:0]        center_mag;
   logic                          is_greater, is_less, found;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cube[i][0] = window_ff[i][0];
         cube[i][1] = window_ff[i][1];
      end
      cube[0][2] = older_eff;
      cube[1][2] = newer_eff;
      cube[2][2] = s1_sample_ff;

      center     = signed'(cube[1][1][SAMPLE_BITS +: SAMPLE_BITS]);
      // the most negative sample keeps its bit pattern, read as unsigned it is right
      center_mag = center[SAMPLE_BITS-1] ? SAMPLE_BITS'(-center) : SAMPLE_BITS'(center);

      is_greater = 1'b1;
      is_less    = 1'b1;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               if (!(i == 1 && j == 1 && k == 1)) begin
                  if (center <= signed'(cube[i][j][k*SAMPLE_BITS +: SAMPLE_BITS])) begin
                     is_greater = 1'b0;
                  end
                  if (center >= signed'(cube[i][j][k*SAMPLE_BITS +: SAMPLE_BITS])) begin
                     is_less = 1'b0;
                  end
               end
            end
         end
      end

      found = s1_valid_ff && s1_interior_ff && (is_greater || is_less)
              && (MAG_BITS'(center_mag) >= MAG_BITS'(threshold_ff));
   end

   // ---------------------------------------------------------------- result queue
   logic [ENTRY_BITS-1:0]        q_ff [RESULT_DEPTH];
   logic [RESULT_PTR_BITS-1:0]   q_wr_ptr_ff, q_rd_ptr_ff;
   logic [RESULT_COUNT_BITS-1:0] q_count_ff, q_count_in;
   logic                         q_push, q_pop;
   logic [ENTRY_BITS-1:0]        q_head;
   logic [CW-1:0]                out_col;
   logic [RB-1:0]                out_row;

   assign q_push = found;
   assign q_pop  = rsp_tvalid && rsp_tready;
   assign out_col = s1_col_ff - CW'(1);
   assign out_row = s1_row_ff - RB'(1);

   always_comb begin
      q_count_in = q_count_ff;
      if (q_push && !q_pop) begin
         q_count_in = q_count_ff + RESULT_COUNT_BITS'(1);
      end else if (q_pop && !q_push) begin
         q_count_in = q_count_ff - RESULT_COUNT_BITS'(1);
      end
   end

   // room for the item in the compare stage and the one accepted now
   assign req_tready = (RESULT_COUNT_BITS'(q_count_ff) + RESULT_COUNT_BITS'(s1_valid_ff))
                       < RESULT_COUNT_BITS'(RESULT_DEPTH);

   assign q_head     = q_ff[q_rd_ptr_ff];
   assign rsp_tvalid = (q_count_ff != '0);
   assign rsp_tdata  = RSP_BITS'(q_head[ENTRY_BITS-2:0]);
   assign rsp_tuser  = q_head[ENTRY_BITS-1];

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         q_wr_ptr_ff  <= '0;
         q_rd_ptr_ff  <= '0;
         q_count_ff   <= '0;
         for (int i = 0; i < 3; i++) begin
            window_ff[i][0] <= '0;
            window_ff[i][1] <= '0;
         end
      end else begin
         if (req_accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         s1_valid_ff  <= req_accept;
         fwd_valid_ff <= fwd_valid_in;
         if (s1_valid_ff) begin
            for (int i = 0; i < 3; i++) begin
               window_ff[i][0] <= window_ff[i][1];
            end
            window_ff[0][1] <= older_eff;
            window_ff[1][1] <= newer_eff;
            window_ff[2][1] <= s1_sample_ff;
         end
         if (q_push) begin
            q_wr_ptr_ff <= q_wr_ptr_ff + RESULT_PTR_BITS'(1);
         end
         if (q_pop) begin
            q_rd_ptr_ff <= q_rd_ptr_ff + RESULT_PTR_BITS'(1);
         end
         q_count_ff <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_col_ff      <= pos_col;
         s1_row_ff      <= pos_row;
         s1_interior_ff <= pos_interior;
         s1_sample_ff   <= req_tdata[TRIO_BITS-1:0];
      end
      if (fwd_valid_in) begin
         fwd_older_ff <= newer_eff;
         fwd_newer_ff <= s1_sample_ff;
      end
      if (q_push) begin
         q_ff[q_wr_ptr_ff] <= {is_greater, SAMPLE_BITS'(center), out_row, out_col};
      end
   end

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= RESULT_COUNT_BITS'(RESULT_DEPTH))
      else $error("result queue count beyond its depth");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_count_ff != RESULT_COUNT_BITS'(RESULT_DEPTH)) || q_pop)
      else $error("result pushed into a full queue");

   a_accept_reaches_compare: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted item did not reach the compare stage");

   a_forward_has_consumer: assert property (@(posedge clock) disable iff (reset)
      fwd_valid_ff |-> s1_valid_ff)
      else $error("line store forward with no item in the compare stage");

   a_result_interior: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (s1_col_ff >= CW'(2)) && (s1_row_ff >= RB'(2)))
      else $error("result reported for a border pixel");
`endif

endmodule : scale_space_extremum_detector

`default_nettype wire
